[src/conv3x3_normalized_image_filter_core_assert.svh]
// Assertion macros used by the checker of the 3x3 filter core.
// No dependencies.
`ifndef CONV3X3_NORMALIZED_IMAGE_FILTER_CORE_ASSERT_SVH
`define CONV3X3_NORMALIZED_IMAGE_FILTER_CORE_ASSERT_SVH
// Implication checked on every rising edge outside reset.
`define C3F_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define C3F_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[src/c3f_pkg.sv]
// Package of the 3x3 filter core: payload types and constants.
// No dependencies.
`default_nettype none
package c3f_pkg;
    localparam int COEF_W = 16;
    localparam int VAL_W  = 24;

    typedef enum logic [2:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_COEF_T  = 3'd2,
        REG_COEF_M  = 3'd3,
        REG_COEF_B  = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIV_IDLE = 2'd0,
        DIV_RUN  = 2'd1,
        DIV_DONE = 2'd2
    } div_state_t;

    // one classified job from front to back
    typedef struct packed {
        logic [7:0]  row;
        logic [7:0]  col;
        logic [7:0]  pix;
        logic        do_int;
        logic        do_brd;
        logic [71:0] win;     // nine pixels, tap order
    } job_t;

    typedef struct packed {
        logic [7:0]        row;
        logic [7:0]        col;
        logic signed [23:0] value;
        logic              border;
        logic              last;
    } res_t;
endpackage
`default_nettype wire

[src/c3f_if.sv]
// Valid/ready channel interfaces for the 3x3 filter core.
// Depends on nothing.
`default_nettype none
interface c3f_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_in;
    modport source (output valid, pixel_in, input ready);
    modport sink   (input valid, pixel_in, output ready);
endinterface

interface c3f_res_if;
    logic              valid;
    logic              ready;
    logic [7:0]        out_row;
    logic [7:0]        out_column;
    logic signed [23:0] out_value;
    logic              is_border;
    logic              last_of_run;
    modport source (output valid, out_row, out_column, out_value, is_border,
                    last_of_run, input ready);
    modport sink   (input valid, out_row, out_column, out_value, is_border,
                    last_of_run, output ready);
endinterface

interface c3f_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/conv3x3_normalized_image_filter_core.sv]
// Top level of the 3x3 normalized convolution filter core.
// Depends on c3f_pkg, the channel interfaces, c3f_front, c3f_queue, c3f_back.
//  channel | dir | carries
//  pix     | in  | pixel_in
//  res     | out | out_row, out_column, out_value, is_border, last_of_run
//  cfg     | in  | index, data (register write)
// The back end holds one pixel at a time; a pixel with an interior result waits for the
// 40-step bit-serial divider (one quotient bit a cycle), and a border copy follows the
// interior result when the pixel has both.
// The front end takes a pixel each cycle until the two-entry queue fills.
// rst_n clears counters, window and handshakes; line buffers are not cleared.
// Either output stall or input idling is absorbed by the queue and output register.
`default_nettype none
module conv3x3_normalized_image_filter_core #(
    parameter int MAX_DIM = 256,
    parameter int COEF_FRAC_BITS = 4
) (
    input wire logic clk,
    input wire logic rst_n,
    c3f_pix_if.sink   pix,
    c3f_res_if.source res,
    c3f_cfg_if.sink   cfg
);
    logic [8:0]  w_reg, h_reg;
    logic [47:0] ct_reg, cm_reg, cb_reg;
    logic fj_valid, fj_ready, qj_valid, qj_ready;
    c3f_pkg::job_t fj, qj;
    c3f_pkg::res_t r;
    logic [143:0] taps;

    // configuration registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= 9'd256;
            h_reg <= 9'd256;
            ct_reg <= 48'hFFEC0000FFEC;
            cm_reg <= 48'h000000A00000;
            cb_reg <= 48'hFFEC0000FFEC;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                c3f_pkg::REG_WIDTH:  w_reg <= cfg.data[8:0];
                c3f_pkg::REG_HEIGHT: h_reg <= cfg.data[8:0];
                c3f_pkg::REG_COEF_T: ct_reg <= cfg.data;
                c3f_pkg::REG_COEF_M: cm_reg <= cfg.data;
                c3f_pkg::REG_COEF_B: cb_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // tap order matches the window: top t0, t1, t2, middle t0..t2, bottom t0..t2
    assign taps = {cb_reg, cm_reg, ct_reg};

    c3f_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk, .rst_n, .in_valid(pix.valid), .in_ready(pix.ready), .pixel(pix.pixel_in),
        .width_cfg(w_reg), .height_cfg(h_reg),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    c3f_queue u_queue (
        .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
        .rd_valid(qj_valid), .rd_ready(qj_ready), .rd_data(qj)
    );

    c3f_back #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_back (
        .clk, .rst_n, .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
        .taps, .res_valid(res.valid), .res_ready(res.ready), .res(r)
    );

    assign res.out_row = r.row;
    assign res.out_column = r.col;
    assign res.out_value = r.value;
    assign res.is_border = r.border;
    assign res.last_of_run = r.last;
endmodule
`default_nettype wire

[src/c3f_front.sv]
// Front end: line buffers, window and position counters; classifies each pixel.
// Depends on c3f_pkg.
`default_nettype none
module c3f_front #(
    parameter int MAX_DIM = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    pixel,
    input  wire logic [8:0]    width_cfg,
    input  wire logic [8:0]    height_cfg,
    output logic               job_valid,
    input  wire logic          job_ready,
    output c3f_pkg::job_t      job
);
    localparam int AW = $clog2(MAX_DIM);
    localparam int CW = $clog2(MAX_DIM + 1);

    logic [7:0] above_mem [MAX_DIM];
    logic [7:0] cur_mem   [MAX_DIM];
    logic [7:0] win_reg [6];
    logic [CW-1:0] row_reg, col_reg;
    logic [CW-1:0] w_eff, h_eff;
    logic [CW-1:0] col_nx;
    logic [AW-1:0] ci, ci_nx;
    logic [7:0] a_rd_reg, c_rd_reg;
    logic fire;
    c3f_pkg::job_t job_reg;
    logic jv_reg;

    // effective frame size
    always_comb
    begin
        if (width_cfg == 9'd0)
            w_eff = CW'(1);
        else if (CW'(width_cfg) > CW'(MAX_DIM) || {23'd0, width_cfg} > MAX_DIM)
            w_eff = CW'(MAX_DIM);
        else
            w_eff = CW'(width_cfg);
        if (height_cfg == 9'd0)
            h_eff = CW'(1);
        else if ({23'd0, height_cfg} > MAX_DIM)
            h_eff = CW'(MAX_DIM);
        else
            h_eff = CW'(height_cfg);
    end

    // column of the next pixel; line buffers are read one pixel ahead
    assign col_nx = (col_reg + CW'(1) >= w_eff) ? '0 : col_reg + CW'(1);
    assign ci = col_reg[AW-1:0];
    assign ci_nx = fire ? col_nx[AW-1:0] : ci;
    assign in_ready = !jv_reg || job_ready;
    assign fire = in_valid && in_ready;
    assign job_valid = jv_reg;
    assign job = job_reg;

    // line buffer update and registered read, bypass when the column repeats
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            above_mem[ci] <= c_rd_reg;
            cur_mem[ci]   <= pixel;
        end
        if (fire && ci_nx == ci)
        begin
            a_rd_reg <= c_rd_reg;
            c_rd_reg <= pixel;
        end
        else
        begin
            a_rd_reg <= above_mem[ci_nx];
            c_rd_reg <= cur_mem[ci_nx];
        end
    end

    // job register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            job_reg.row <= 8'(row_reg);
            job_reg.col <= 8'(col_reg);
            job_reg.pix <= pixel;
            job_reg.do_int <= row_reg >= CW'(2) && col_reg >= CW'(2)
                              && col_reg <= w_eff - CW'(1);
            job_reg.do_brd <= row_reg == '0 || row_reg >= h_eff - CW'(1)
                              || col_reg == '0 || col_reg >= w_eff - CW'(1);
            job_reg.win <= {win_reg[0], win_reg[3], a_rd_reg,
                            win_reg[1], win_reg[4], c_rd_reg,
                            win_reg[2], win_reg[5], pixel};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jv_reg  <= 1'b0;
            row_reg <= '0;
            col_reg <= '0;
            for (int k = 0; k < 6; k++)
                win_reg[k] <= 8'd0;
        end
        else
        begin
            if (fire)
                jv_reg <= 1'b1;
            else if (job_ready)
                jv_reg <= 1'b0;
            if (fire)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= a_rd_reg;
                win_reg[4] <= c_rd_reg;
                win_reg[5] <= pixel;
                col_reg <= col_nx;
                if (col_reg + CW'(1) >= w_eff)
                    row_reg <= (row_reg + CW'(1) >= h_eff) ? '0 : row_reg + CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

[src/c3f_queue.sv]
// Two-entry job queue between front and back.
// Depends on c3f_pkg.
`default_nettype none
module c3f_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire c3f_pkg::job_t wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output c3f_pkg::job_t      rd_data
);
    c3f_pkg::job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

[src/c3f_back.sv]
// Back end: weighted sum, serial normalizing divide, clamp, result emission.
// Depends on c3f_pkg.
`default_nettype none
module c3f_back #(
    parameter int COEF_FRAC_BITS = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire c3f_pkg::job_t job,
    input  wire logic [143:0]  taps,   // nine 16-bit taps, tap order
    output logic               res_valid,
    input  wire logic          res_ready,
    output c3f_pkg::res_t      res
);
    // acc magnitude < 9*255*32768 < 2^27; 40 bits is ample
    localparam int AW = 40;
    localparam int QW = AW;

    c3f_pkg::div_state_t st_reg, st_next;
    logic signed [AW-1:0] prod_reg [9];
    logic signed [AW-1:0] acc, raw, num_c;
    logic signed [19:0] csum;
    logic [1:0] ph_reg;           // 0: job taken, 1: products, 2: sum
    logic [AW-1:0] num_reg, quo_reg, rem_reg;
    logic [19:0] den_reg;
    logic neg_reg;
    logic [6:0] cnt_reg;
    logic signed [AW-1:0] raw_reg;
    logic signed [19:0] csum_reg;
    logic busy_reg;
    c3f_pkg::job_t j_reg;
    logic ov_reg;
    c3f_pkg::res_t ob_reg;
    logic int_pend_reg, brd_pend_reg;
    logic [AW:0] rem_sh;
    logic signed [AW-1:0] q_s;
    logic [23:0] v_int;
    logic out_free;
    logic emit_int, emit_brd;

    assign out_free = !ov_reg || res_ready;
    assign res_valid = ov_reg;
    assign res = ob_reg;
    assign job_ready = !busy_reg;

    // result loads into the output register
    assign emit_int = busy_reg && ph_reg == 2'd2 && int_pend_reg
                      && st_reg == c3f_pkg::DIV_DONE && out_free;
    assign emit_brd = busy_reg && ph_reg == 2'd2 && !int_pend_reg && brd_pend_reg
                      && out_free;

    // adder tree over the registered products and tap sum
    always_comb
    begin
        acc = '0;
        csum = '0;
        for (int k = 0; k < 9; k++)
        begin
            acc = acc + prod_reg[k];
            csum = csum + 20'(signed'(taps[16*k +: 16]));
        end
        raw = acc >>> COEF_FRAC_BITS;
        if (acc < 0 && (acc & AW'((1 << COEF_FRAC_BITS) - 1)) != 0)
            raw = raw + AW'(1);
        num_c = raw <<< COEF_FRAC_BITS;
    end

    // divider state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            c3f_pkg::DIV_IDLE: if (busy_reg && ph_reg == 2'd2 && int_pend_reg)
                                   st_next = c3f_pkg::DIV_RUN;
            c3f_pkg::DIV_RUN:  if (cnt_reg == 7'(QW - 1))
                                   st_next = c3f_pkg::DIV_DONE;
            c3f_pkg::DIV_DONE: if (out_free)
                                   st_next = c3f_pkg::DIV_IDLE;
            default:           st_next = c3f_pkg::DIV_IDLE;
        endcase
    end

    assign rem_sh = {rem_reg, num_reg[AW-1]};
    assign q_s = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    // interior value
    always_comb
    begin
        if (csum_reg != 0)
        begin
            if (q_s < 0)
                v_int = 24'd0;
            else if (q_s > 255)
                v_int = 24'd255;
            else
                v_int = q_s[23:0];
        end
        else if (raw_reg > AW'(8388607))
            v_int = 24'h7FFFFF;
        else if (raw_reg < -AW'(8388608))
            v_int = 24'h800000;
        else
            v_int = raw_reg[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && !busy_reg)
            j_reg <= job;
        for (int k = 0; k < 9; k++)
            prod_reg[k] <= AW'(signed'(taps[16*k +: 16]))
                           * AW'(signed'({1'b0, j_reg.win[8*(8-k) +: 8]}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= c3f_pkg::DIV_IDLE;
            busy_reg <= 1'b0;
            ph_reg <= 2'd0;
            ov_reg <= 1'b0;
            int_pend_reg <= 1'b0;
            brd_pend_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (emit_int || emit_brd)
                ov_reg <= 1'b1;
            else if (res_ready)
                ov_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (job_valid)
                begin
                    busy_reg <= 1'b1;
                    ph_reg <= 2'd0;
                    int_pend_reg <= job.do_int;
                    brd_pend_reg <= job.do_brd;
                end
            end
            else if (ph_reg != 2'd2)
                ph_reg <= ph_reg + 2'd1;
            else if (int_pend_reg)
            begin
                case (st_reg)
                    c3f_pkg::DIV_IDLE:
                    begin
                        raw_reg <= raw;
                        csum_reg <= csum;
                        neg_reg <= (num_c < 0) != (csum < 0);
                        num_reg <= num_c < 0 ? AW'(-num_c) : AW'(num_c);
                        den_reg <= csum < 0 ? 20'(-csum) : 20'(csum);
                        rem_reg <= '0;
                        quo_reg <= '0;
                        cnt_reg <= '0;
                    end
                    c3f_pkg::DIV_RUN:
                    begin
                        num_reg <= num_reg << 1;
                        if (rem_sh >= {{(AW-19){1'b0}}, den_reg})
                        begin
                            rem_reg <= AW'(rem_sh - {{(AW-19){1'b0}}, den_reg});
                            quo_reg <= {quo_reg[AW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh[AW-1:0];
                            quo_reg <= {quo_reg[AW-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                    c3f_pkg::DIV_DONE:
                        if (out_free)
                        begin
                            ob_reg <= '{row: j_reg.row - 8'd1, col: j_reg.col - 8'd1,
                                        value: v_int, border: 1'b0,
                                        last: !brd_pend_reg};
                            int_pend_reg <= 1'b0;
                            if (!brd_pend_reg)
                                busy_reg <= 1'b0;
                        end
                    default: ;
                endcase
            end
            else if (brd_pend_reg)
            begin
                if (out_free)
                begin
                    ob_reg <= '{row: j_reg.row, col: j_reg.col,
                                value: {16'd0, j_reg.pix}, border: 1'b1, last: 1'b1};
                    brd_pend_reg <= 1'b0;
                    busy_reg <= 1'b0;
                end
            end
            else
                busy_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

[src/c3f_checker.sv]
// Port-level checker for the 3x3 filter core, bound to the top level.
// Depends on the assertion macro header.
`default_nettype none
`include "conv3x3_normalized_image_filter_core_assert.svh"
module c3f_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        is_border,
    input wire logic        last_of_run,
    input wire logic signed [23:0] out_value
);
    `C3F_ASSERT_IMPL(a_border_last, clk, rst_n, res_valid && is_border, last_of_run)
    `C3F_ASSERT_IMPL(a_border_range, clk, rst_n, res_valid && is_border,
        out_value >= 0 && out_value <= 255)
    `C3F_ASSERT_NEXT(a_hold, clk, rst_n, res_valid && !res_ready, res_valid)
endmodule

bind conv3x3_normalized_image_filter_core c3f_checker u_chk (
    .clk(clk), .rst_n(rst_n), .res_valid(res.valid), .res_ready(res.ready),
    .is_border(res.is_border), .last_of_run(res.last_of_run), .out_value(res.out_value)
);
`default_nettype wire
